[hw/rtl/lsr_pkg.sv]
`default_nettype none

package lsr_pkg;

    localparam int CHAR_W   = 8;
    localparam int LABEL_W  = 7;
    localparam int ATOM_W   = CHAR_W + LABEL_W;
    localparam int COUNT_W  = 13;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_CHARS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_HIGH      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPL_LENGTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LIMIT   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd4096;

    typedef struct packed {
        logic signed [LABEL_W-1:0] label;
        logic [CHAR_W-1:0]         chr;
    } atom_t;

    typedef struct packed {
        logic                      is_atom;
        logic [CHAR_W-1:0]         chr;
        logic signed [LABEL_W-1:0] label;
        logic                      last;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } result_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/lsr_cell.sv]
`default_nettype none

module lsr_cell (
    input  wire logic                          clk,
    input  wire lsr_pkg::cell_ctrl_t           ctrl,
    input  wire lsr_pkg::atom_t                in_atom,
    input  wire lsr_pkg::atom_t                right_atom,
    input  wire logic [lsr_pkg::CHAR_W-1:0]    pat_char,
    output lsr_pkg::atom_t                     atom_q,
    output logic                               char_match
);

    lsr_pkg::atom_t atom_reg;
    lsr_pkg::atom_t atom_next;

    always_comb
    begin
        priority if (ctrl.load)
        begin
            atom_next = in_atom;
        end
        else if (ctrl.shift)
        begin
            atom_next = right_atom;
        end
        else
        begin
            atom_next = atom_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        atom_reg <= atom_next;
    end

    assign atom_q     = atom_reg;
    assign char_match = (atom_reg.chr == pat_char);

endmodule

`default_nettype wire

[hw/rtl/lsr_out_fifo.sv]
`default_nettype none

module lsr_out_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire lsr_pkg::result_t push_data,
    output logic                  full,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output lsr_pkg::result_t      m_data
);

    lsr_pkg::result_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pop;

    assign pop     = m_valid && m_ready;
    assign m_valid = (cnt_reg != 2'd0);
    assign full    = (cnt_reg == 2'd2);
    assign m_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/labeled_substring_replace.sv]
// Leftmost, non-overlapping find-and-replace over a stream of labeled atoms.
// Input s_* carries one atom per item (tuser = carries_atom, tlast = end of
// text). Output m_* carries emitted atoms (tuser = 1) and one summary item
// per text (tuser = 0, tlast = 1) with status and emitted count.
// The window is a row of PATTERN_MAX cells that shift toward cell 0 as the
// oldest atom leaves; each cell compares its char with its pattern char.
// An atom that leaves the window is written into the 2-entry output queue
// when the item that pushed it out is accepted, and shows on m_* from there.
// Throughput: one item per cycle while no match occurs and the output queue
// has room. A match holds the input while the sequencer sends the
// replacement atoms (length capped at REPL_MAX; none when the replacement is
// empty or would overflow), one atom per cycle while the queue has room. End
// of text holds the input while the window is flushed and the summary sent.
// When m_tready is low the output queue fills and s_tready drops once it
// holds two results; nothing is lost. Configuration is taken at any time
// but must only be written between texts or while idle; a write of
// pattern_length empties the window.
// Reset restores the register defaults (pattern_length 1, output_limit 4096)
// and empties the window, count and overflow flag.
`default_nettype none

module labeled_substring_replace #(
    parameter int PATTERN_MAX = 8,
    parameter int REPL_MAX    = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // atom_char [7:0], atom_label [14:8]
    input  wire logic        s_tuser,   // carries_atom
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_char [7:0], out_label [14:8],
                                        // status [16:15], out_count [29:17]
    output logic             m_tuser,   // is_atom
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam int FW  = $clog2(PATTERN_MAX + 1);
    localparam int RKW = $clog2(REPL_MAX + 1);
    localparam int CW  = lsr_pkg::COUNT_W;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_REPL    = 2'd1;
    localparam logic [1:0] MODE_FLUSH   = 2'd2;
    localparam logic [1:0] MODE_SUMMARY = 2'd3;

    // configuration
    logic [63:0]   pat_chars_reg;
    logic [3:0]    pat_len_reg;
    logic [59:0]   repl_lo_reg;
    logic [59:0]   repl_hi_reg;
    logic [3:0]    repl_len_reg;
    logic [CW-1:0] limit_reg;
    logic          cfg_we;

    // text state
    logic [FW-1:0]  fill_reg, fill_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           ovf_reg, ovf_next;
    logic [1:0]     mode_reg, mode_next;
    logic [RKW-1:0] rk_reg, rk_next;
    logic           eot_reg, eot_next;

    logic [FW-1:0]  plen;
    logic [FW-1:0]  fill_p1;
    logic [RKW-1:0] rn;
    logic           accept;
    logic           win_match;
    logic           emit_ok;
    logic           emit_ovf;
    logic           repl_fits;
    logic           go_repl;
    logic           fifo_full;
    logic           push;

    lsr_pkg::atom_t     in_atom;
    lsr_pkg::atom_t     pop_atom;
    lsr_pkg::atom_t     rep_atom;
    lsr_pkg::result_t   push_data;
    lsr_pkg::result_t   out_data;
    lsr_pkg::atom_t     cell_q     [PATTERN_MAX];
    lsr_pkg::atom_t     cell_right [PATTERN_MAX];
    lsr_pkg::cell_ctrl_t cell_ctrl [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_match;

    assign in_atom.chr   = s_tdata[7:0];
    assign in_atom.label = s_tdata[14:8];

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign s_tready  = (mode_reg == MODE_IDLE) && !fifo_full;
    assign accept    = s_tvalid && s_tready;

    assign plen = (pat_len_reg > 4'(PATTERN_MAX)) ? FW'(PATTERN_MAX) : pat_len_reg[FW-1:0];
    assign rn   = (repl_len_reg > 4'(REPL_MAX)) ? RKW'(REPL_MAX) : repl_len_reg[RKW-1:0];
    assign fill_p1 = fill_reg + FW'(1);

    assign emit_ok   = !ovf_reg && (count_reg < limit_reg);
    assign emit_ovf  = !ovf_reg && !(count_reg < limit_reg);
    assign repl_fits = (({1'b0, count_reg} + (CW + 1)'(rn)) <= {1'b0, limit_reg});

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            if (gi == PATTERN_MAX - 1)
            begin : g_end
                assign cell_right[gi] = in_atom;
            end
            else
            begin : g_mid
                assign cell_right[gi] = cell_q[gi + 1];
            end

            lsr_cell u_cell (
                .clk        (clk),
                .ctrl       (cell_ctrl[gi]),
                .in_atom    (in_atom),
                .right_atom (cell_right[gi]),
                .pat_char   (pat_chars_reg[8*gi +: 8]),
                .atom_q     (cell_q[gi]),
                .char_match (cell_match[gi])
            );
        end
    endgenerate

    // window holds fill atoms; the incoming one completes it at slot fill
    always_comb
    begin
        win_match = 1'b1;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            if ((FW'(k) < fill_reg) && !cell_match[k])
            begin
                win_match = 1'b0;
            end
            if ((FW'(k) == fill_reg) && (in_atom.chr != pat_chars_reg[8*k +: 8]))
            begin
                win_match = 1'b0;
            end
        end
    end

    always_comb
    begin
        rep_atom = '0;
        for (int k = 0; k < REPL_MAX; k++)
        begin
            if (RKW'(k) == rk_reg)
            begin
                rep_atom = (k < 4) ? lsr_pkg::atom_t'(repl_lo_reg[15*(k%4) +: 15])
                                   : lsr_pkg::atom_t'(repl_hi_reg[15*(k%4) +: 15]);
            end
        end
    end

    assign pop_atom = (fill_reg == '0) ? in_atom : cell_q[0];

    always_comb
    begin
        fill_next  = fill_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        mode_next  = mode_reg;
        rk_next    = rk_reg;
        eot_next   = eot_reg;
        go_repl    = 1'b0;
        push       = 1'b0;
        push_data  = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            cell_ctrl[i] = '0;
        end

        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser && (plen != '0))
                    begin
                        if (fill_p1 == plen)
                        begin
                            if (win_match)
                            begin
                                fill_next = '0;
                                if (!ovf_reg)
                                begin
                                    if (!repl_fits)
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                    else if (rn != '0)
                                    begin
                                        go_repl   = 1'b1;
                                        mode_next = MODE_REPL;
                                        rk_next   = '0;
                                    end
                                end
                            end
                            else
                            begin
                                // drop the oldest atom out, new one lands at fill - 1
                                for (int i = 0; i < PATTERN_MAX; i++)
                                begin
                                    cell_ctrl[i].shift = 1'b1;
                                    cell_ctrl[i].load  = (FW'(i + 1) == fill_reg);
                                end
                                if (emit_ok)
                                begin
                                    push            = 1'b1;
                                    push_data.is_atom = 1'b1;
                                    push_data.chr   = pop_atom.chr;
                                    push_data.label = pop_atom.label;
                                    push_data.count = count_reg + CW'(1);
                                    count_next      = count_reg + CW'(1);
                                end
                                else if (emit_ovf)
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < PATTERN_MAX; i++)
                            begin
                                cell_ctrl[i].load = (FW'(i) == fill_reg);
                            end
                            fill_next = fill_p1;
                        end
                    end
                    eot_next = s_tlast;
                    if (s_tlast && !go_repl)
                    begin
                        mode_next = (fill_next != '0) ? MODE_FLUSH : MODE_SUMMARY;
                    end
                end
            end

            MODE_REPL:
            begin
                if (!fifo_full)
                begin
                    push              = 1'b1;
                    push_data.is_atom = 1'b1;
                    push_data.chr     = rep_atom.chr;
                    push_data.label   = rep_atom.label;
                    push_data.count   = count_reg + CW'(1);
                    count_next        = count_reg + CW'(1);
                    rk_next           = rk_reg + RKW'(1);
                    if (rk_reg == rn - RKW'(1))
                    begin
                        mode_next = eot_reg ? MODE_SUMMARY : MODE_IDLE;
                    end
                end
            end

            MODE_FLUSH:
            begin
                if (!fifo_full)
                begin
                    for (int i = 0; i < PATTERN_MAX; i++)
                    begin
                        cell_ctrl[i].shift = 1'b1;
                    end
                    fill_next = fill_reg - FW'(1);
                    if (emit_ok)
                    begin
                        push              = 1'b1;
                        push_data.is_atom = 1'b1;
                        push_data.chr     = cell_q[0].chr;
                        push_data.label   = cell_q[0].label;
                        push_data.count   = count_reg + CW'(1);
                        count_next        = count_reg + CW'(1);
                    end
                    else if (emit_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    if (fill_reg == FW'(1))
                    begin
                        mode_next = MODE_SUMMARY;
                    end
                end
            end

            MODE_SUMMARY:
            begin
                if (!fifo_full)
                begin
                    push           = 1'b1;
                    push_data.last = 1'b1;
                    if (plen == '0)
                    begin
                        push_data.status = lsr_pkg::ST_EMPTY;
                        push_data.count  = '0;
                    end
                    else
                    begin
                        push_data.status = ovf_reg ? lsr_pkg::ST_OVERFLOW : lsr_pkg::ST_OK;
                        push_data.count  = count_reg;
                    end
                    count_next = '0;
                    ovf_next   = 1'b0;
                    fill_next  = '0;
                    eot_next   = 1'b0;
                    mode_next  = MODE_IDLE;
                end
            end

            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase

        // a new pattern length empties the window
        if (cfg_we && (cfg_index == lsr_pkg::CFG_PATTERN_LENGTH))
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_chars_reg <= '0;
            pat_len_reg   <= 4'd1;
            repl_lo_reg   <= '0;
            repl_hi_reg   <= '0;
            repl_len_reg  <= '0;
            limit_reg     <= lsr_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lsr_pkg::CFG_PATTERN_CHARS:  pat_chars_reg <= cfg_data;
                lsr_pkg::CFG_PATTERN_LENGTH: pat_len_reg   <= cfg_data[3:0];
                lsr_pkg::CFG_REPL_LOW:       repl_lo_reg   <= cfg_data[59:0];
                lsr_pkg::CFG_REPL_HIGH:      repl_hi_reg   <= cfg_data[59:0];
                lsr_pkg::CFG_REPL_LENGTH:    repl_len_reg  <= cfg_data[3:0];
                lsr_pkg::CFG_OUTPUT_LIMIT:   limit_reg     <= cfg_data[CW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            mode_reg  <= MODE_IDLE;
            rk_reg    <= '0;
            eot_reg   <= 1'b0;
        end
        else
        begin
            fill_reg  <= fill_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            mode_reg  <= mode_next;
            rk_reg    <= rk_next;
            eot_reg   <= eot_next;
        end
    end

    lsr_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_data    (out_data)
    );

    assign m_tdata = {2'b00, out_data.count, out_data.status, out_data.label, out_data.chr};
    assign m_tuser = out_data.is_atom;
    assign m_tlast = out_data.last;

    a_fill_below_plen: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) || (fill_reg < plen))
        else $error("window fill reached pattern length");

    a_repl_index: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_REPL) |-> ((rn != '0) && (rk_reg < rn) && (fill_reg == '0)))
        else $error("replacement sequencer out of range");

    a_flush_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_FLUSH) |-> (fill_reg != '0))
        else $error("flush with empty window");

    a_summary_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (push && push_data.last) |=> ((count_reg == '0) && !ovf_reg && (mode_reg == MODE_IDLE)))
        else $error("text state not cleared after summary");

endmodule

`default_nettype wire
